// File: rtl/core/qphms_pkg.sv
`timescale 1ns / 1ps

package qphms_pkg;

  // Window geometry default
  localparam int DEFAULT_WINDOW_DEPTH = 8;

  // QP value that is never recorded
  localparam logic [7:0] IGNORED_QP = 8'hff;

  // Register reset values
  localparam logic       RST_ENABLE    = 1'b0;
  localparam logic [7:0] RST_FLAT_TH   = 8'd46;
  localparam logic [7:0] RST_MEDIUM_TH = 8'd48;
  localparam logic [7:0] RST_STRONG_TH = 8'd50;
  localparam logic [7:0] RST_PANIC_QP  = 8'd51;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_ENABLE,
    REG_FLAT_TH,
    REG_MEDIUM_TH,
    REG_STRONG_TH,
    REG_PANIC_QP
  } reg_index_t;

  // Input item kinds
  typedef enum logic {
    KIND_RECORD,
    KIND_DECIDE
  } kind_t;

  // Quantization matrix codes
  typedef enum logic [1:0] {
    MTX_FLAT,
    MTX_MEDIUM,
    MTX_STRONG,
    MTX_EXTREME
  } matrix_t;

  // Back-end sequencer states
  typedef enum logic [2:0] {
    BK_IDLE,
    BK_UPDATE,
    BK_PREP,
    BK_DIV,
    BK_DONE
  } back_state_t;

  // Live configuration
  typedef struct packed {
    logic       enable;
    logic [7:0] flat_th;
    logic [7:0] medium_th;
    logic [7:0] strong_th;
    logic [7:0] panic_qp;
  } cfg_t;

  // Classified transaction handed from front to back
  typedef struct packed {
    logic       push;      // QP goes into the window
    logic       decide;    // matrix decision wanted (already gated by enable)
    logic [7:0] qp;
    logic       recoding;
  } item_t;

endpackage

// File: rtl/core/qphms_front.sv
`timescale 1ns / 1ps

module qphms_front import qphms_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       enable,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] qp_value,
  input  logic       recoding,
  output logic       q_valid,
  output item_t      q_item,
  input  logic       q_pop
);

  item_t       entries [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  fill;
  item_t       cls;
  logic        push_en;
  logic        pop_en;

  // Classify the incoming transaction
  always_comb begin
    cls.push     = enable && (kind_t'(kind) == KIND_RECORD) && (qp_value != IGNORED_QP);
    cls.decide   = enable && (kind_t'(kind) == KIND_DECIDE);
    cls.qp       = qp_value;
    cls.recoding = recoding;
  end

  assign in_stall = (fill == 2'd2);
  assign push_en  = in_valid && !in_stall;
  assign q_valid  = (fill != 2'd0);
  assign pop_en   = q_pop && q_valid;
  assign q_item   = entries[rd_ptr];

  // Queue pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push_en) wr_ptr <= ~wr_ptr;
      if (pop_en)  rd_ptr <= ~rd_ptr;
      fill <= fill + {1'b0, push_en} - {1'b0, pop_en};
    end
  end

  // Queue storage
  always_ff @(posedge clk) begin
    if (push_en) entries[wr_ptr] <= cls;
  end

endmodule

// File: rtl/core/qphms_back.sv
`timescale 1ns / 1ps

module qphms_back import qphms_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst,
  input  cfg_t                              cfg,
  input  logic                              q_valid,
  input  item_t                             q_item,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [7:0]                        average_qp,
  output logic [1:0]                        matrix_choice,
  output logic                              custom_selected,
  output logic [$clog2(WINDOW_DEPTH+1)-1:0] window_count
);

  localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = 8 + CNT_W;
  localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
  localparam int ITER_W = $clog2(SUM_W);

  back_state_t        state, state_next;
  item_t              cur;
  logic [7:0]         mem [WINDOW_DEPTH];
  logic [7:0]         rd_data;
  logic [SLOT_W-1:0]  oldest_slot;
  logic [SUM_W-1:0]   window_sum;
  logic [SUM_W-1:0]   num;
  logic [CNT_W-1:0]   rem;
  logic [ITER_W-1:0]  iter;
  logic               out_load;
  logic               full;
  logic [CNT_W:0]     slot_sum;
  logic [SLOT_W-1:0]  fill_slot;
  logic [CNT_W:0]     trial;
  logic               ge;
  logic [CNT_W:0]     trial_diff;
  logic [7:0]         avg;
  matrix_t            choice;

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    out_load   = 1'b0;
    unique case (state)
      BK_IDLE: begin
        q_pop = q_valid;
        if (q_valid) state_next = BK_UPDATE;
      end
      BK_UPDATE: state_next = BK_PREP;
      BK_PREP:   state_next = BK_DIV;
      BK_DIV: begin
        if (iter == '0) state_next = BK_DONE;
      end
      BK_DONE: begin
        out_load = !out_valid || !out_stall;
        if (out_load) state_next = BK_IDLE;
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // Window bookkeeping
  assign full      = (window_count == CNT_W'(WINDOW_DEPTH));
  assign slot_sum  = (CNT_W+1)'(oldest_slot) + {1'b0, window_count};
  assign fill_slot = (slot_sum >= (CNT_W+1)'(WINDOW_DEPTH)) ?
                     SLOT_W'(slot_sum - (CNT_W+1)'(WINDOW_DEPTH)) : SLOT_W'(slot_sum);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_count <= '0;
      oldest_slot  <= '0;
      window_sum   <= '0;
    end else if (state == BK_UPDATE && cur.push) begin
      if (full) begin
        window_sum  <= window_sum - SUM_W'(rd_data) + SUM_W'(cur.qp);
        oldest_slot <= (oldest_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : oldest_slot + 1'b1;
      end else begin
        window_sum   <= window_sum + SUM_W'(cur.qp);
        window_count <= window_count + 1'b1;
      end
    end
  end

  // Window memory: oldest entry is read every cycle, valid in BK_UPDATE
  always_ff @(posedge clk) begin
    rd_data <= mem[oldest_slot];
    if (state == BK_UPDATE && cur.push) begin
      mem[full ? oldest_slot : fill_slot] <= cur.qp;
    end
  end

  // Current transaction
  always_ff @(posedge clk) begin
    if (q_pop) cur <= q_item;
  end

  // Restoring divider, one quotient bit per cycle
  assign trial      = {rem, num[SUM_W-1]};
  assign ge         = (trial >= {1'b0, window_count});
  assign trial_diff = trial - {1'b0, window_count};

  always_ff @(posedge clk) begin
    if (state == BK_PREP) begin
      num  <= window_sum + SUM_W'(window_count >> 1);
      rem  <= '0;
      iter <= ITER_W'(SUM_W - 1);
    end else if (state == BK_DIV) begin
      num  <= {num[SUM_W-2:0], ge};
      rem  <= ge ? trial_diff[CNT_W-1:0] : trial[CNT_W-1:0];
      iter <= iter - 1'b1;
    end
  end

  // Matrix decision
  assign avg = (window_count == '0) ? 8'd0 : num[7:0];

  always_comb begin
    choice = MTX_FLAT;
    if (cur.decide) begin
      priority if (cur.recoding && cur.qp == cfg.panic_qp) choice = MTX_EXTREME;
      else if (avg == 8'd0)          choice = MTX_FLAT;
      else if (avg < cfg.flat_th)    choice = MTX_FLAT;
      else if (avg < cfg.medium_th)  choice = MTX_MEDIUM;
      else if (avg < cfg.strong_th)  choice = MTX_STRONG;
      else                           choice = MTX_EXTREME;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      average_qp      <= avg;
      matrix_choice   <= choice;
      custom_selected <= (choice != MTX_FLAT);
    end
  end

endmodule

// File: rtl/core/qp_history_matrix_selector.sv
`timescale 1ns / 1ps
// The back end handles one transaction at a time: it pops the next one from the
//   two-entry queue only after the last result is loaded into the output register.
// Throughput is set by the bit-serial restoring divider that forms the rounded average
//   (SUM_W = 8 + clog2(WINDOW_DEPTH+1), 12 at the default depth of 8).
// Reset: synchronous, clears the window count, sum, queue and output valid,
//   and loads the register defaults; window entries are not cleared.

module qp_history_matrix_selector import qphms_pkg::*; #(
  parameter int WINDOW_DEPTH = DEFAULT_WINDOW_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [2:0] cfg_index,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       kind,
  input  logic [7:0] qp_value,
  input  logic       recoding,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] average_qp,
  output logic [1:0] matrix_choice,
  output logic       custom_selected
);

  localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);

  cfg_t              cfg;
  logic              q_valid;
  item_t             q_item;
  logic              q_pop;
  logic [CNT_W-1:0]  window_count;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable    <= RST_ENABLE;
      cfg.flat_th   <= RST_FLAT_TH;
      cfg.medium_th <= RST_MEDIUM_TH;
      cfg.strong_th <= RST_STRONG_TH;
      cfg.panic_qp  <= RST_PANIC_QP;
    end else if (cfg_we) begin
      unique case (reg_index_t'(cfg_index))
        REG_ENABLE:    cfg.enable    <= cfg_data[0];
        REG_FLAT_TH:   cfg.flat_th   <= cfg_data;
        REG_MEDIUM_TH: cfg.medium_th <= cfg_data;
        REG_STRONG_TH: cfg.strong_th <= cfg_data;
        REG_PANIC_QP:  cfg.panic_qp  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Accept and classify
  qphms_front u_front (
    .clk      (clk),
    .rst      (rst),
    .enable   (cfg.enable),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .kind     (kind),
    .qp_value (qp_value),
    .recoding (recoding),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Window update, average and decision
  qphms_back #(
    .WINDOW_DEPTH (WINDOW_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_valid         (q_valid),
    .q_item          (q_item),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .average_qp      (average_qp),
    .matrix_choice   (matrix_choice),
    .custom_selected (custom_selected),
    .window_count    (window_count)
  );

  // Window never holds more than its depth
  assert property (@(posedge clk) disable iff (rst)
    window_count <= CNT_W'(WINDOW_DEPTH))
    else $error("window count beyond depth");

  // Custom flag tracks a non-flat matrix
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (custom_selected == (matrix_choice != MTX_FLAT)))
    else $error("custom flag disagrees with matrix choice");

  // Count never falls, so an empty window means the shown average is zero
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && window_count == '0) |-> (average_qp == 8'd0))
    else $error("nonzero average with empty window");

  // A popped transaction leaves the queue with room for the next one
  assert property (@(posedge clk) disable iff (rst)
    q_pop |=> !in_stall)
    else $error("queue still full after pop");

endmodule

// File: dv/qp_history_matrix_selector_tb.sv
`timescale 1ns / 1ps

module qp_history_matrix_selector_tb;
  import qphms_pkg::*;

  localparam int DEPTH        = DEFAULT_WINDOW_DEPTH;
  localparam int SETTLE       = 24;      // a margin past the result latency
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_WAIT     = 10;

  // Expected result of one transaction
  typedef struct {
    logic [7:0] average;
    matrix_t    choice;
    logic       custom;
  } verdict_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       cfg_we = 1'b0;
  logic [2:0] cfg_index = REG_ENABLE;
  logic [7:0] cfg_data = 8'd0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic       kind = KIND_RECORD;
  logic [7:0] qp_value = 8'd0;
  logic       recoding = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] average_qp;
  logic [1:0] matrix_choice;
  logic       custom_selected;

  qp_history_matrix_selector dut (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .kind(kind),
    .qp_value(qp_value),
    .recoding(recoding),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .average_qp(average_qp),
    .matrix_choice(matrix_choice),
    .custom_selected(custom_selected)
  );

  // Clock
  initial begin
    forever #5 clk = ~clk;
  end

  // Mirror of the live registers
  logic       sel_enable  = RST_ENABLE;
  logic [7:0] sel_flat    = RST_FLAT_TH;
  logic [7:0] sel_medium  = RST_MEDIUM_TH;
  logic [7:0] sel_strong  = RST_STRONG_TH;
  logic [7:0] sel_panic   = RST_PANIC_QP;

  // Mirror of the QP window
  logic [7:0] win_qp [DEPTH];
  int         win_count  = 0;
  int         win_oldest = 0;
  int         win_sum    = 0;

  verdict_t   verdict_q [$];

  int  errors       = 0;
  int  checked      = 0;
  int  sent         = 0;
  int  directed     = 0;
  int  settings     = 0;
  int  cycle_count  = 0;
  bit  gaps_on      = 1'b1;
  bit  stalls_on    = 1'b1;
  int  hold_left    = 0;
  int  stall_left   = 0;

  // Window update and matrix decision for one transaction
  function automatic verdict_t predict_verdict(kind_t k, logic [7:0] qp, logic rec);
    verdict_t v;
    int       avg;
    if (k == KIND_RECORD && sel_enable && qp != IGNORED_QP) begin
      if (win_count == DEPTH) begin
        win_sum            = win_sum - win_qp[win_oldest] + qp;
        win_qp[win_oldest] = qp;
        win_oldest         = (win_oldest + 1) % DEPTH;
      end else begin
        win_qp[(win_oldest + win_count) % DEPTH] = qp;
        win_sum   = win_sum + qp;
        win_count = win_count + 1;
      end
    end
    avg       = (win_count == 0) ? 0 : (win_sum + win_count / 2) / win_count;
    v.average = avg[7:0];
    v.choice  = MTX_FLAT;
    if (k == KIND_DECIDE && sel_enable) begin
      if (rec && qp == sel_panic) v.choice = MTX_EXTREME;
      else if (avg == 0 || avg < sel_flat) v.choice = MTX_FLAT;
      else if (avg < sel_medium) v.choice = MTX_MEDIUM;
      else if (avg < sel_strong) v.choice = MTX_STRONG;
      else v.choice = MTX_EXTREME;
    end
    v.custom = (v.choice != MTX_FLAT);
    return v;
  endfunction

  // Send one transaction after a random gap; returns at the accepting edge
  task automatic send_item(kind_t k, logic [7:0] qp, logic rec);
    int gap;
    gap = gaps_on ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    kind     <= k;
    qp_value <= qp;
    recoding <= rec;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    verdict_q.insert(verdict_q.size(), predict_verdict(k, qp, rec));
    sent++;
  endtask

  // Stop offering and wait until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Write all five registers back to back; block must be idle
  task automatic load_config(logic en, logic [7:0] flat, logic [7:0] medium_th,
                             logic [7:0] strong_th, logic [7:0] panic);
    reg_index_t regs [5];
    logic [7:0] vals [5];
    regs = '{REG_ENABLE, REG_FLAT_TH, REG_MEDIUM_TH, REG_STRONG_TH, REG_PANIC_QP};
    vals = '{{7'd0, en}, flat, medium_th, strong_th, panic};
    for (int i = 0; i < 5; i++) begin
      cfg_we    <= 1'b1;
      cfg_index <= regs[i];
      cfg_data  <= vals[i];
      @(posedge clk);
    end
    cfg_we     <= 1'b0;
    sel_enable = en;
    sel_flat   = flat;
    sel_medium = medium_th;
    sel_strong = strong_th;
    sel_panic  = panic;
    settings++;
  endtask

  // QPs cluster around the live thresholds so averages land near the boundaries
  function automatic logic [7:0] pick_qp();
    int r;
    int center;
    r = $urandom_range(0, 15);
    if (r == 0) return IGNORED_QP;
    if (r <= 3) return 8'($urandom_range(0, 255));
    case ($urandom_range(0, 3))
      0: center = sel_flat;
      1: center = sel_medium;
      2: center = sel_strong;
      default: center = sel_panic;
    endcase
    center = center + $urandom_range(0, 8) - 4;
    if (center < 0) center = 0;
    if (center > 254) center = 254;
    return 8'(center);
  endfunction

  task automatic random_item();
    logic [7:0] qp;
    logic       rec;
    rec = 1'($urandom_range(0, 1));
    if ($urandom_range(0, 1) == 0) begin
      send_item(KIND_RECORD, pick_qp(), rec);
    end else begin
      qp = ($urandom_range(0, 3) == 0) ? sel_panic : pick_qp();
      send_item(KIND_DECIDE, qp, rec);
    end
  endtask

  // Disabled behavior, empty window, ignored QP, zero average, wrap, panic
  task automatic test_directed();
    send_item(KIND_RECORD, 8'd60, 1'b0);
    send_item(KIND_DECIDE, RST_PANIC_QP, 1'b1);
    drain();
    load_config(1'b1, RST_FLAT_TH, RST_MEDIUM_TH, RST_STRONG_TH, RST_PANIC_QP);
    send_item(KIND_DECIDE, RST_PANIC_QP, 1'b1);
    send_item(KIND_DECIDE, 8'd0, 1'b0);
    send_item(KIND_RECORD, IGNORED_QP, 1'b0);
    send_item(KIND_RECORD, 8'd0, 1'b1);
    send_item(KIND_DECIDE, 8'd0, 1'b0);
    send_item(KIND_RECORD, 8'd254, 1'b0);
    send_item(KIND_DECIDE, 8'd254, 1'b1);
    // eight more records wrap the window and push out 0 and 254
    repeat (DEPTH) send_item(KIND_RECORD, 8'd47, 1'b0);
    send_item(KIND_DECIDE, RST_PANIC_QP, 1'b0);
    send_item(KIND_DECIDE, RST_PANIC_QP, 1'b1);
    drain();
    // disabled again: window kept, no recording, flat choice
    load_config(1'b0, RST_FLAT_TH, RST_MEDIUM_TH, RST_STRONG_TH, RST_PANIC_QP);
    send_item(KIND_RECORD, 8'd200, 1'b0);
    send_item(KIND_DECIDE, 8'd255, 1'b1);
    drain();
    directed = sent;
  endtask

  // Random traffic under a range of register settings, extremes included
  task automatic test_threshold_sweeps();
    for (int p = 0; p < 9; p++) begin
      case (p)
        0: load_config(1'b1, RST_FLAT_TH, RST_MEDIUM_TH, RST_STRONG_TH, RST_PANIC_QP);
        1: load_config(1'b1, 8'd0, 8'd0, 8'd0, 8'd0);
        2: load_config(1'b1, 8'd255, 8'd255, 8'd255, 8'd255);
        3: load_config(1'b1, 8'd200, 8'd100, 8'd150, 8'd254);
        4: load_config(1'b1, 8'd1, 8'd1, 8'd255, 8'd0);
        5: load_config(1'b0, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        default: load_config(1'b1, 8'($urandom_range(0, 80)), 8'($urandom_range(40, 160)),
                             8'($urandom_range(100, 255)), 8'($urandom));
      endcase
      repeat (90) random_item();
      drain();
    end
  endtask

  // Receiver holds off long enough for the block to fill and stall its input
  task automatic test_output_holdoff();
    load_config(1'b1, 8'd30, 8'd60, 8'd90, 8'd45);
    hold_left = 400;
    repeat (30) random_item();
    // sender waits for every outstanding result before going on
    drain();
    repeat (30) random_item();
    hold_left = 250;
    repeat (30) random_item();
    drain();
  endtask

  // Back-to-back transactions with no gaps and no stalls
  task automatic test_streaming();
    gaps_on   = 1'b0;
    stalls_on = 1'b0;
    load_config(1'b1, RST_FLAT_TH, RST_MEDIUM_TH, RST_STRONG_TH, RST_PANIC_QP);
    repeat (150) random_item();
    drain();
    gaps_on   = 1'b1;
    stalls_on = 1'b1;
  endtask

  // Receiver: random stall per result, counted while a result is offered
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      stall_left = stalls_on ? $urandom_range(0, MAX_WAIT) : 0;
    end else if (out_valid && stall_left > 0) begin
      stall_left--;
    end
    out_stall <= (hold_left > 0) || (stall_left > 0);
    if (hold_left > 0) hold_left--;
  end

  // Result checker
  always @(posedge clk) begin
    verdict_t v;
    if (!rst && out_valid && !out_stall) begin
      if (verdict_q.size() == 0) begin
        $display("%0t: unexpected result avg=%0d choice=%0d custom=%0d", $time,
                 average_qp, matrix_choice, custom_selected);
        errors++;
      end else begin
        v = verdict_q[0];
        verdict_q.delete(0);
        checked++;
        if (average_qp !== v.average) begin
          $display("%0t: average_qp expected %0d actual %0d", $time, v.average, average_qp);
          errors++;
        end
        if (matrix_choice !== v.choice) begin
          $display("%0t: matrix_choice expected %0d actual %0d", $time, v.choice,
                   matrix_choice);
          errors++;
        end
        if (custom_selected !== v.custom) begin
          $display("%0t: custom_selected expected %0d actual %0d", $time, v.custom,
                   custom_selected);
          errors++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d results outstanding", $time,
               cycle_count, verdict_q.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_threshold_sweeps();
    test_output_holdoff();
    test_streaming();
    if (verdict_q.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, verdict_q.size());
      errors++;
    end
    $display("Sent %0d transactions (%0d directed) under %0d register settings,",
             sent, directed, settings);
    $display("with long output hold-off and gapless streaming; %0d results checked.",
             checked);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

// File: filelist.f
rtl/core/qphms_pkg.sv
rtl/core/qphms_front.sv
rtl/core/qphms_back.sv
rtl/core/qp_history_matrix_selector.sv
dv/qp_history_matrix_selector_tb.sv
